[rtl/spc_pkg.sv]
// Shared types and constants for the shape pair collision test.
// Shape descriptor, kind codes and internal arithmetic widths.
// No dependencies.
package spc_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    // doubled coordinate plus or minus a full size, with headroom
    localparam int WIDE_W  = 19;
    // magnitude of any doubled distance on one axis
    localparam int MAG_W   = 17;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RECT = 2'd1;
    localparam logic [1:0] KIND_CIRC = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [SIZE_W-1:0]         radius;
    } shape_t;

endpackage

[rtl/spc_pair_eval.sv]
// Combinational overlap evaluation for one registered shape pair.
// Depends on spc_pkg.
module spc_pair_eval
    import spc_pkg::*;
(
    input  shape_t a_shape,
    input  shape_t b_shape,
    output logic   hit
);

    function automatic logic signed [WIDE_W-1:0] dbl_coord(input logic signed [COORD_W-1:0] v);
        return $signed({{(WIDE_W-COORD_W-1){v[COORD_W-1]}}, v, 1'b0});
    endfunction

    function automatic logic signed [WIDE_W-1:0] ext_size(input logic [SIZE_W-1:0] v);
        return $signed({{(WIDE_W-SIZE_W){1'b0}}, v});
    endfunction

    // distance from c to the interval [lo, hi]
    function automatic logic [MAG_W-1:0] axis_gap(input logic signed [WIDE_W-1:0] c,
                                                  input logic signed [WIDE_W-1:0] lo,
                                                  input logic signed [WIDE_W-1:0] hi);
        logic signed [WIDE_W-1:0] d;
        d = '0;
        if (c > hi) begin
            d = c - hi;
        end else if (c < lo) begin
            d = lo - c;
        end
        return d[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [WIDE_W-1:0] p,
                                                  input logic signed [WIDE_W-1:0] q);
        logic signed [WIDE_W-1:0] d;
        d = p - q;
        if (d < 0) begin
            d = -d;
        end
        return d[MAG_W-1:0];
    endfunction

    logic a_rect, a_circ, b_rect, b_circ;
    logic signed [WIDE_W-1:0] ax2, ay2, aw, ah, bx2, by2, bw, bh;
    logic rect_hit;

    shape_t rect_s, circ_s;
    logic signed [WIDE_W-1:0] rx2, ry2, rw, rh, cx2, cy2;

    logic [MAG_W-1:0] dx, dy, rad;
    logic [2*MAG_W-1:0] dx_sq, dy_sq, rad_sq;
    logic [2*MAG_W:0]   dist_sq;
    logic dist_hit;

    assign a_rect = (a_shape.kind == KIND_RECT);
    assign a_circ = (a_shape.kind == KIND_CIRC);
    assign b_rect = (b_shape.kind == KIND_RECT);
    assign b_circ = (b_shape.kind == KIND_CIRC);

    assign ax2 = dbl_coord(a_shape.x);
    assign ay2 = dbl_coord(a_shape.y);
    assign aw  = ext_size(a_shape.width);
    assign ah  = ext_size(a_shape.height);
    assign bx2 = dbl_coord(b_shape.x);
    assign by2 = dbl_coord(b_shape.y);
    assign bw  = ext_size(b_shape.width);
    assign bh  = ext_size(b_shape.height);

    // strict overlap, touching edges miss
    assign rect_hit = (ax2 - aw < bx2 + bw) && (ax2 + aw > bx2 - bw) &&
                      (ay2 - ah < by2 + bh) && (ay2 + ah > by2 - bh);

    assign rect_s = a_rect ? a_shape : b_shape;
    assign circ_s = a_rect ? b_shape : a_shape;
    assign rx2 = dbl_coord(rect_s.x);
    assign ry2 = dbl_coord(rect_s.y);
    assign rw  = ext_size(rect_s.width);
    assign rh  = ext_size(rect_s.height);
    assign cx2 = dbl_coord(circ_s.x);
    assign cy2 = dbl_coord(circ_s.y);

    always_comb begin
        if (a_circ && b_circ) begin
            dx  = abs_diff(ax2, bx2);
            dy  = abs_diff(ay2, by2);
            rad = MAG_W'({a_shape.radius, 1'b0}) + MAG_W'({b_shape.radius, 1'b0});
        end else begin
            dx  = axis_gap(cx2, rx2 - rw, rx2 + rw);
            dy  = axis_gap(cy2, ry2 - rh, ry2 + rh);
            rad = MAG_W'({circ_s.radius, 1'b0});
        end
    end

    assign dx_sq   = (2*MAG_W)'(dx) * (2*MAG_W)'(dx);
    assign dy_sq   = (2*MAG_W)'(dy) * (2*MAG_W)'(dy);
    assign rad_sq  = (2*MAG_W)'(rad) * (2*MAG_W)'(rad);
    assign dist_sq = (2*MAG_W+1)'(dx_sq) + (2*MAG_W+1)'(dy_sq);
    assign dist_hit = (dist_sq <= (2*MAG_W+1)'(rad_sq));

    always_comb begin
        if (a_rect && b_rect) begin
            hit = rect_hit;
        end else if ((a_circ && b_circ) || (a_rect && b_circ) || (a_circ && b_rect)) begin
            hit = dist_hit;
        end else begin
            hit = 1'b0;
        end
    end

endmodule

[rtl/shape_pair_collision_test.sv]
// Top level of the shape pair collision test.
// Depends on spc_pkg and spc_pair_eval.
//
// Takes one shape pair per transaction and returns one hit flag per pair, in order.
// A pair is registered at the input, evaluated in a single combinational pass
// (axis clamping, three squares and one compare) and the flag is registered at the output.
// A new pair is taken every cycle unless both stages are full and m_ready is low.
// The output register lets a new pair enter while a finished flag waits for m_ready.
// Kind codes: 0 none, 1 rectangle, 2 circle; code 3 behaves as none.
module shape_pair_collision_test
    import spc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_a_kind,
    input  logic signed [COORD_W-1:0] s_a_x,
    input  logic signed [COORD_W-1:0] s_a_y,
    input  logic [SIZE_W-1:0]         s_a_width,
    input  logic [SIZE_W-1:0]         s_a_height,
    input  logic [SIZE_W-1:0]         s_a_radius,
    input  logic [1:0]                s_b_kind,
    input  logic signed [COORD_W-1:0] s_b_x,
    input  logic signed [COORD_W-1:0] s_b_y,
    input  logic [SIZE_W-1:0]         s_b_width,
    input  logic [SIZE_W-1:0]         s_b_height,
    input  logic [SIZE_W-1:0]         s_b_radius,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit
);

    logic   in_valid_reg, in_valid_next;
    logic   out_valid_reg, out_valid_next;
    shape_t a_reg, b_reg;
    logic   hit_reg;
    logic   eval_hit;
    logic   out_free;
    logic   s_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_reg <= '{kind: s_a_kind, x: s_a_x, y: s_a_y, width: s_a_width,
                       height: s_a_height, radius: s_a_radius};
            b_reg <= '{kind: s_b_kind, x: s_b_x, y: s_b_y, width: s_b_width,
                       height: s_b_height, radius: s_b_radius};
        end
        if (out_free && in_valid_reg) begin
            hit_reg <= eval_hit;
        end
    end

    spc_pair_eval u_eval (
        .a_shape (a_reg),
        .b_shape (b_reg),
        .hit     (eval_hit)
    );

    assign m_valid = out_valid_reg;
    assign m_hit   = hit_reg;

endmodule

[rtl/spc_checker.sv]
// Port-level checks for the shape pair collision test, bound to the top level.
// Depends on spc_pkg and shape_pair_collision_test.
module spc_checker
    import spc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_a_kind,
    input logic [1:0] s_b_kind,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_hit
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("result changed while stalled");

    // input only backs up when both stages are full and the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // a fresh result follows an accepted transaction through the input and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input transaction");

    // pairs with an empty shape never hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && $past(s_valid && s_ready &&
            (s_a_kind == KIND_NONE || s_b_kind == KIND_NONE), 2) |-> !m_hit)
        else $error("hit reported for an empty shape");

endmodule

bind shape_pair_collision_test spc_checker u_spc_checker (.*);

[sim/shape_pair_collision_test_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for shape_pair_collision_test: directed and random shape pairs
// under random idling and back-pressure, each m_hit transaction checked against a predictor.
// Depends on spc_pkg and the shape_pair_collision_test RTL.
module shape_pair_collision_test_test;
    import spc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic [1:0]                s_a_kind   = '0;
    logic signed [COORD_W-1:0] s_a_x      = '0;
    logic signed [COORD_W-1:0] s_a_y      = '0;
    logic [SIZE_W-1:0]         s_a_width  = '0;
    logic [SIZE_W-1:0]         s_a_height = '0;
    logic [SIZE_W-1:0]         s_a_radius = '0;
    logic [1:0]                s_b_kind   = '0;
    logic signed [COORD_W-1:0] s_b_x      = '0;
    logic signed [COORD_W-1:0] s_b_y      = '0;
    logic [SIZE_W-1:0]         s_b_width  = '0;
    logic [SIZE_W-1:0]         s_b_height = '0;
    logic [SIZE_W-1:0]         s_b_radius = '0;
    logic                      m_ready    = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic                      m_hit;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   error_count   = 0;
    int   stall_cycles  = 0;
    int   hold_count    = 0;
    logic hold_req      = 1'b0;
    bit   expected_hits[$];
    bit   exp_hit;

    shape_pair_collision_test i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_a_kind  (s_a_kind),
        .s_a_x     (s_a_x),
        .s_a_y     (s_a_y),
        .s_a_width (s_a_width),
        .s_a_height(s_a_height),
        .s_a_radius(s_a_radius),
        .s_b_kind  (s_b_kind),
        .s_b_x     (s_b_x),
        .s_b_y     (s_b_y),
        .s_b_width (s_b_width),
        .s_b_height(s_b_height),
        .s_b_radius(s_b_radius),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit)
    );

    always #1 aclk = ~aclk;

    function automatic shape_t make_shape(input logic [1:0] kind, input logic [15:0] x,
                                          input logic [15:0] y, input logic [14:0] width,
                                          input logic [14:0] height, input logic [14:0] radius);
        shape_t s;
        s.kind   = kind;
        s.x      = x;
        s.y      = y;
        s.width  = width;
        s.height = height;
        s.radius = radius;
        return s;
    endfunction

    // all coordinates doubled so half sizes stay exact
    function automatic bit circle_meets_rect(input shape_t r, input shape_t c);
        longint rx, ry, rw, rh, cx, cy, cr, px, py;
        rx = 2 * longint'(r.x);
        ry = 2 * longint'(r.y);
        rw = longint'(r.width);
        rh = longint'(r.height);
        cx = 2 * longint'(c.x);
        cy = 2 * longint'(c.y);
        cr = longint'(c.radius);
        cr = 2 * cr;
        px = cx;
        if (px > rx + rw) px = rx + rw;
        if (px < rx - rw) px = rx - rw;
        py = cy;
        if (py > ry + rh) py = ry + rh;
        if (py < ry - rh) py = ry - rh;
        return (cx - px) * (cx - px) + (cy - py) * (cy - py) <= cr * cr;
    endfunction

    function automatic bit predict_hit(input shape_t a, input shape_t b);
        longint ax, ay, bx, by, aw, ah, bw, bh, rs;
        ax = 2 * longint'(a.x);
        ay = 2 * longint'(a.y);
        bx = 2 * longint'(b.x);
        by = 2 * longint'(b.y);
        aw = longint'(a.width);
        ah = longint'(a.height);
        bw = longint'(b.width);
        bh = longint'(b.height);
        rs = longint'(a.radius);
        rs = 2 * (rs + longint'(b.radius));
        if (a.kind == KIND_RECT && b.kind == KIND_RECT)
            return (ax - aw < bx + bw) && (ax + aw > bx - bw) &&
                   (ay - ah < by + bh) && (ay + ah > by - bh);
        if (a.kind == KIND_CIRC && b.kind == KIND_CIRC)
            return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) <= rs * rs;
        if (a.kind == KIND_RECT && b.kind == KIND_CIRC)
            return circle_meets_rect(a, b);
        if (a.kind == KIND_CIRC && b.kind == KIND_RECT)
            return circle_meets_rect(b, a);
        return 1'b0;
    endfunction

    function automatic int axis_extent(input shape_t s, input bit y_axis);
        if (s.kind == KIND_CIRC) return 2 * int'(s.radius);
        return y_axis ? int'(s.height) : int'(s.width);
    endfunction

    // receiver: random ready, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_count <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // scoreboard and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result transaction, hit %0b", $time, m_hit);
                    error_count++;
                end else begin
                    exp_hit = expected_hits.pop_front();
                    if (m_hit !== exp_hit) begin
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, exp_hit, m_hit);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_hits.push_back(predict_hit(
                    make_shape(s_a_kind, s_a_x, s_a_y, s_a_width, s_a_height, s_a_radius),
                    make_shape(s_b_kind, s_b_x, s_b_y, s_b_width, s_b_height, s_b_radius)));
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, stall_cycles);
                $display("*** FAILED ***");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_pair(input shape_t a, input shape_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_a_kind   <= a.kind;
        s_a_x      <= a.x;
        s_a_y      <= a.y;
        s_a_width  <= a.width;
        s_a_height <= a.height;
        s_a_radius <= a.radius;
        s_b_kind   <= b.kind;
        s_b_x      <= b.x;
        s_b_y      <= b.y;
        s_b_width  <= b.width;
        s_b_height <= b.height;
        s_b_radius <= b.radius;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_pairs(input int count);
        shape_t sh[2];
        int     r, lim, reach, off;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 2; k++) begin
                r = $urandom_range(15);
                if (r == 0) sh[k].kind = KIND_NONE;
                else if (r == 1) sh[k].kind = KIND_UNUSED;
                else sh[k].kind = r[0] ? KIND_RECT : KIND_CIRC;
                sh[k].x      = COORD_W'($urandom);
                sh[k].y      = COORD_W'($urandom);
                lim          = (1 << $urandom_range(15, 2)) - 1;
                sh[k].width  = SIZE_W'($urandom_range(lim, 0));
                sh[k].height = SIZE_W'($urandom_range(lim, 0));
                sh[k].radius = SIZE_W'($urandom_range(lim, 0));
            end
            // most pairs placed close together, around the touching distance
            if ($urandom_range(3) != 0) begin
                for (int ax_i = 0; ax_i < 2; ax_i++) begin
                    reach = (axis_extent(sh[0], ax_i[0]) + axis_extent(sh[1], ax_i[0])) / 2;
                    case ($urandom_range(2))
                        0: off = reach + $urandom_range(4) - 2;
                        1: off = $urandom_range(reach);
                        default: off = reach * $urandom_range(3) / 2;
                    endcase
                    if ($urandom_range(1)) off = -off;
                    if (ax_i == 1) sh[1].y = sh[0].y + off[15:0];
                    else sh[1].x = sh[0].x + off[15:0];
                end
            end
            send_pair(sh[0], sh[1]);
        end
    endtask

    task automatic test_null_kinds();
        send_pair(make_shape(KIND_NONE, 0, 0, 64, 64, 32), make_shape(KIND_RECT, 0, 0, 64, 64, 0));
        send_pair(make_shape(KIND_RECT, 0, 0, 64, 64, 0), make_shape(KIND_NONE, 0, 0, 64, 64, 32));
        send_pair(make_shape(KIND_NONE, 0, 0, 0, 0, 0), make_shape(KIND_NONE, 0, 0, 0, 0, 0));
        send_pair(make_shape(KIND_UNUSED, 5, 5, 64, 64, 64),
                  make_shape(KIND_CIRC, 5, 5, 0, 0, 64));
        send_pair(make_shape(KIND_CIRC, 5, 5, 0, 0, 64),
                  make_shape(KIND_UNUSED, 5, 5, 64, 64, 64));
    endtask

    task automatic test_rect_pairs();
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_RECT, 31, 0, 32, 32, 0));
        // edges touching on x, then on y: no hit
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_RECT, 32, 0, 32, 32, 0));
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_RECT, 0, -32, 32, 32, 0));
        send_pair(make_shape(KIND_RECT, 7, 7, 0, 0, 100), make_shape(KIND_RECT, 7, 7, 0, 0, 100));
        send_pair(make_shape(KIND_RECT, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 15'h7fff),
                  make_shape(KIND_RECT, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 15'h7fff));
        send_pair(make_shape(KIND_RECT, 16'h8000, 16'h7fff, 15'h7fff, 15'h7fff, 0),
                  make_shape(KIND_RECT, 0, 0, 15'h7fff, 15'h7fff, 0));
    endtask

    task automatic test_circle_pairs();
        send_pair(make_shape(KIND_CIRC, 0, 0, 0, 0, 2), make_shape(KIND_CIRC, 3, 4, 0, 0, 3));
        send_pair(make_shape(KIND_CIRC, 0, 0, 0, 0, 2), make_shape(KIND_CIRC, 3, 4, 0, 0, 2));
        send_pair(make_shape(KIND_CIRC, 9, 9, 0, 0, 0), make_shape(KIND_CIRC, 9, 9, 0, 0, 0));
        send_pair(make_shape(KIND_CIRC, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 15'h7fff),
                  make_shape(KIND_CIRC, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 15'h7fff));
        send_pair(make_shape(KIND_CIRC, 16'h8000, 0, 0, 0, 15'h7fff),
                  make_shape(KIND_CIRC, 16'h7fff, 0, 0, 0, 15'h7fff));
    endtask

    task automatic test_rect_circle_pairs();
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_CIRC, 3, -2, 0, 0, 1));
        // corner touching, corner near miss, side touching
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_CIRC, 19, 20, 0, 0, 5));
        send_pair(make_shape(KIND_RECT, 0, 0, 32, 32, 0), make_shape(KIND_CIRC, 19, 20, 0, 0, 4));
        send_pair(make_shape(KIND_CIRC, -26, 0, 0, 0, 10), make_shape(KIND_RECT, 0, 0, 32, 32, 0));
        send_pair(make_shape(KIND_CIRC, -27, 0, 0, 0, 10), make_shape(KIND_RECT, 0, 0, 32, 32, 0));
        send_pair(make_shape(KIND_RECT, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 15'h7fff),
                  make_shape(KIND_CIRC, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 15'h7fff));
        send_pair(make_shape(KIND_CIRC, 16'h7fff, 16'h8000, 0, 0, 0),
                  make_shape(KIND_RECT, 16'h8000, 16'h7fff, 0, 0, 0));
    endtask

    task automatic test_random_pairs(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        send_random_pairs(count);
    endtask

    // receiver holds off while transactions keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        s_valid  <= 1'b0;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        send_random_pairs(40);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 10;
        recv_idle_pct = 86;
        test_null_kinds();
        test_rect_pairs();
        test_circle_pairs();
        test_rect_circle_pairs();
        test_random_pairs(10, 86, 430);
        test_random_pairs(86, 10, 430);
        test_backpressure();
        test_random_pairs(0, 0, 430);
        s_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
